[rtl/text_console_writer_macros.svh]
// Assertion macros for the text console writer.
// Used by the top level only; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Plain implication checked at every clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Antecedent in this cycle, consequent in the next
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; imported by the controller, datapath, top level and testbench.
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COL_IN_W  = 7;
  localparam int ROW_IN_W  = 5;
  localparam int OFF_W     = 11;
  localparam int CELL_W    = 16;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] CLEAR_CELL   = 16'h0F20;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRITE,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SW_HOLD,
    SW_ZERO,
    SW_FILL,
    SW_INC
  } sweep_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CHAR,
    WR_FILL,
    WR_CLEAR
  } wr_kind_e;

  typedef struct packed {
    logic     load_item;
    logic     exec;
    logic     rd_cell;
    logic     copy_step;
    sweep_e   sweep;
    wr_kind_e wr;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  scroll;
    logic  copy_end;
    logic  cell_end;
  } status_t;

endpackage

[rtl/tcw_ctrl.sv]
// Sequencing controller for the text console writer.
// Depends on tcw_pkg; drives the datapath through cmd_t and reads status_t.
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '{load_item: 1'b0, exec: 1'b0, rd_cell: 1'b0, copy_step: 1'b0,
                   sweep: SW_HOLD, wr: WR_NONE, load_out: 1'b0};
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.mode)
          MODE_PUT:   state_d = ST_WRITE;
          MODE_SET:   state_d = ST_DONE;
          MODE_CLEAR: begin
            cmd_o.sweep = SW_ZERO;
            state_d     = ST_CLEAR;
          end
          default: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = ST_DONE;
          end
        endcase
      end
      ST_WRITE: begin
        cmd_o.wr = WR_CHAR;
        if (status_i.scroll) begin
          cmd_o.sweep = SW_ZERO;
          state_d     = ST_COPY;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        // shift every row up by one, one cell per cycle
        cmd_o.copy_step = 1'b1;
        if (status_i.copy_end) begin
          cmd_o.sweep = SW_FILL;
          state_d     = ST_DRAIN;
        end else begin
          cmd_o.sweep = SW_INC;
        end
      end
      ST_DRAIN: begin
        // let the last copied cell land before the fill starts
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.wr = WR_FILL;
        if (status_i.cell_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.sweep = SW_INC;
        end
      end
      ST_CLEAR: begin
        cmd_o.wr = WR_CLEAR;
        if (status_i.cell_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.sweep = SW_INC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/tcw_datapath.sv]
// Datapath of the text console writer: cursor, attribute, screen store,
// sweep counter and result register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                cfg_valid_i,
  input  logic [ATTR_W-1:0]   cfg_data_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COL_IN_W-1:0] column_i,
  input  logic [ROW_IN_W-1:0] row_i,
  output logic [COL_IN_W-1:0] cursor_column_o,
  output logic [ROW_IN_W-1:0] cursor_row_o,
  output logic [OFF_W-1:0]    cursor_offset_o,
  output logic [CELL_W-1:0]   cell_data_o
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int FILL_BASE = (ROWS - 1) * COLUMNS;
  localparam int COPY_LAST = FILL_BASE - 1;
  localparam int CELL_LAST = CELLS - 1;

  logic [CELL_W-1:0] screen_mem [CELLS];

  logic [ATTR_W-1:0] attr_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic              scroll_q;
  logic              tgt_we_q;
  logic              wb_valid_q;
  logic [ADDR_W-1:0] sweep_q;

  mode_e             mode_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  col_in_q;
  logic [ROW_W-1:0]  row_in_q;
  logic [COL_W-1:0]  tgt_col_q;
  logic [ROW_W-1:0]  tgt_row_q;
  logic [CHAR_W-1:0] tgt_ch_q;
  logic [ADDR_W-1:0] wb_addr_q;
  logic [CELL_W-1:0] rd_data_q;

  logic [COL_IN_W-1:0] out_col_q;
  logic [ROW_IN_W-1:0] out_row_q;
  logic [OFF_W-1:0]    out_off_q;
  logic [CELL_W-1:0]   out_cell_q;

  // put-character decode
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    put_col_ext;
  logic              put_row_adv;
  logic              put_row_back;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              put_scroll;
  logic              put_we;
  logic [COL_W-1:0]  put_wcol;
  logic [ROW_W-1:0]  put_wrow;
  logic [CHAR_W-1:0] put_wch;

  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] tgt_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  // Latch the item with the row and column clamped to the screen
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q   <= mode_e'(mode_i);
      char_q   <= char_code_i;
      col_in_q <= (int'(column_i) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(column_i);
      row_in_q <= (int'(row_i) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(row_i);
    end
  end

  always_comb begin
    col_ext      = {1'b0, cur_col_q};
    put_col_ext  = col_ext;
    put_row_adv  = 1'b0;
    put_row_back = 1'b0;
    put_we       = 1'b0;
    put_wcol     = cur_col_q;
    put_wrow     = cur_row_q;
    put_wch      = char_q;
    put_scroll   = 1'b0;

    if (char_q == CH_BACKSPACE) begin
      if (cur_col_q != '0) begin
        put_col_ext = col_ext - (COL_W+1)'(1);
        put_we      = 1'b1;
        put_wcol    = cur_col_q - COL_W'(1);
        put_wch     = CH_SPACE;
      end else if (cur_row_q != '0) begin
        // wrap back to the last column of the previous row
        put_row_back = 1'b1;
        put_col_ext  = (COL_W+1)'(COLUMNS - 1);
        put_we       = 1'b1;
        put_wcol     = COL_W'(COLUMNS - 1);
        put_wrow     = cur_row_q - ROW_W'(1);
        put_wch      = CH_SPACE;
      end
    end else if (char_q == CH_TAB) begin
      put_col_ext = (col_ext + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
    end else if (char_q == CH_RETURN) begin
      put_col_ext = '0;
    end else if (char_q == CH_NEWLINE) begin
      put_col_ext = '0;
      put_row_adv = 1'b1;
    end else if (char_q >= CH_SPACE) begin
      put_we      = 1'b1;
      put_col_ext = col_ext + (COL_W+1)'(1);
    end

    if (int'(put_col_ext) >= COLUMNS) begin
      put_col_ext = '0;
      put_row_adv = 1'b1;
    end
    put_col = COL_W'(put_col_ext);

    put_row = cur_row_q;
    if (put_row_back) begin
      put_row = cur_row_q - ROW_W'(1);
    end else if (put_row_adv) begin
      if (int'(cur_row_q) == ROWS - 1) begin
        put_scroll = 1'b1;
      end else begin
        put_row = cur_row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      scroll_q  <= 1'b0;
      tgt_we_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      case (mode_q)
        MODE_PUT: begin
          cur_col_q <= put_col;
          cur_row_q <= put_row;
          scroll_q  <= put_scroll;
          tgt_we_q  <= put_we;
        end
        MODE_SET: begin
          cur_col_q <= col_in_q;
          cur_row_q <= row_in_q;
          scroll_q  <= 1'b0;
          tgt_we_q  <= 1'b0;
        end
        MODE_CLEAR: begin
          cur_col_q <= '0;
          cur_row_q <= '0;
          scroll_q  <= 1'b0;
          tgt_we_q  <= 1'b0;
        end
        default: begin
          scroll_q <= 1'b0;
          tgt_we_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      tgt_col_q <= put_wcol;
      tgt_row_q <= put_wrow;
      tgt_ch_q  <= put_wch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      case (cmd_i.sweep)
        SW_ZERO: sweep_q <= '0;
        SW_FILL: sweep_q <= ADDR_W'(FILL_BASE);
        SW_INC:  sweep_q <= sweep_q + ADDR_W'(1);
        default: sweep_q <= sweep_q;
      endcase
    end
  end

  assign in_addr  = ADDR_W'(row_in_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_in_q);
  assign tgt_addr = ADDR_W'(tgt_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col_q);
  assign cur_addr = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);

  // Write port: a pending scroll copy first, then the controller's request
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_addr;
    mem_wdata = {attr_q, tgt_ch_q};
    if (wb_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_q;
      mem_wdata = rd_data_q;
    end else begin
      case (cmd_i.wr)
        WR_CHAR: mem_we = tgt_we_q;
        WR_FILL: begin
          mem_we    = 1'b1;
          mem_waddr = sweep_q;
          mem_wdata = {attr_q, CH_SPACE};
        end
        WR_CLEAR: begin
          mem_we    = 1'b1;
          mem_waddr = sweep_q;
          mem_wdata = CLEAR_CELL;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  assign mem_re    = cmd_i.rd_cell | cmd_i.copy_step;
  assign mem_raddr = cmd_i.copy_step ? sweep_q + ADDR_W'(COLUMNS) : in_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= screen_mem[mem_raddr];
    end
  end

  // A copied cell is written back one row higher in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= cmd_i.copy_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_step) begin
      wb_addr_q <= sweep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_col_q  <= COL_IN_W'(cur_col_q);
      out_row_q  <= ROW_IN_W'(cur_row_q);
      out_off_q  <= OFF_W'(cur_addr);
      out_cell_q <= (mode_q == MODE_READ) ? rd_data_q : '0;
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.scroll   = scroll_q;
  assign status_o.copy_end = (sweep_q == ADDR_W'(COPY_LAST));
  assign status_o.cell_end = (sweep_q == ADDR_W'(CELL_LAST));

  assign cursor_column_o = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_offset_o = out_off_q;
  assign cell_data_o     = out_cell_q;

endmodule

[rtl/text_console_writer.sv]
// Top level of the text-mode console engine: stream ports, config port.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and the assertion macro header.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  s_axis  | in        | tvalid / tready       | mode, char_code, column, row
//  m_axis  | out       | tvalid / tready       | cursor col/row/offset, cell_data
//  cfg     | in        | cfg_valid / cfg_ready | text_attribute
//
// Set cursor and read cell pass through states IDLE, EXEC and DONE, put
// character also through WRITE; the screen store has one write and one read
// port, so a scroll copies the upper rows up one cell at a time, drains and
// blanks the bottom row, and clear screen blanks each cell in turn. Items are
// taken one at a time; a result waits in the output register while the next
// item is accepted. Reset clears cursor, attribute and control; the screen
// store is not cleared and holds nothing defined until written.
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] mode, [9:2] char_code, [16:10] column, [21:17] row, [23:22] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] cursor_column, [11:7] cursor_row, [22:12] cursor_offset,
  // [38:23] cell_data, [39] zero
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  logic [COL_IN_W-1:0] cursor_column;
  logic [ROW_IN_W-1:0] cursor_row;
  logic [OFF_W-1:0]    cursor_offset;
  logic [CELL_W-1:0]   cell_data;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (s_axis_tdata_i[1:0]),
    .char_code_i     (s_axis_tdata_i[9:2]),
    .column_i        (s_axis_tdata_i[16:10]),
    .row_i           (s_axis_tdata_i[21:17]),
    .cursor_column_o (cursor_column),
    .cursor_row_o    (cursor_row),
    .cursor_offset_o (cursor_offset),
    .cell_data_o     (cell_data)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {1'b0, cell_data, cursor_offset, cursor_row, cursor_column};

  // One item in flight: no new transfer straight after an accepted one
  `TCW_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "item accepted while busy")
  // A held result is never overwritten before its transfer
  `TCW_ASSERT(a_no_overwrite, cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i), "pending result overwritten")
  // Reported cursor column stays on the screen
  `TCW_ASSERT(a_col_range, m_axis_tvalid_o |-> (int'(m_axis_tdata_o[6:0]) < COLUMNS), "cursor column off screen")

endmodule

[tb/text_console_writer_tb.sv]
// Self-checking testbench for the text console writer: stream requests in, cursor/cell results out.
// Keeps a shadow screen, cursor and attribute in step with every accepted request and attribute write.
// Depends on tcw_pkg and the text_console_writer top level only.
module text_console_writer_tb import tcw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS          = DEF_COLUMNS;
  localparam int ROWS          = DEF_ROWS;
  localparam int CELLS         = COLS * ROWS;
  localparam int RANDOM_ITEMS  = 1720;
  localparam int RANDOM_PHASES = 8;
  localparam int HEAVY_BUDGET  = 150;    // scrolls and clears each walk the whole store
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 3_000_000;

  // Packed so that mode lands in the lowest bits, as on s_axis_tdata
  typedef struct packed {
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] column;
    logic [CHAR_W-1:0]   char_code;
    mode_e               mode;
  } console_req_t;

  // Packed so that cursor_column lands in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic [CELL_W-1:0]   cell_data;
    logic [OFF_W-1:0]    cursor_offset;
    logic [ROW_IN_W-1:0] cursor_row;
    logic [COL_IN_W-1:0] cursor_column;
  } console_view_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = '0;

  // Shadow state of the console
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int unsigned       cur_col = 0;
  int unsigned       cur_row = 0;
  logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;
  console_view_t     view_q[$];

  bit rx_hold_req  = 1'b0;
  int heavy_left   = HEAVY_BUDGET;
  int scroll_count = 0;
  int clear_count  = 0;
  int sent_count   = 0;
  int seen_count   = 0;
  int cfg_count    = 0;
  int hold_count   = 0;
  int err_count    = 0;

  always #10 clk_i = ~clk_i;

  text_console_writer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  function automatic void put_cell(int unsigned c, int unsigned r, logic [CHAR_W-1:0] ch);
    shadow_screen[r * COLS + c] = {shadow_attr, ch};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {shadow_attr, CH_SPACE};
    scroll_count++;
  endfunction

  function automatic void apply_char(logic [CHAR_W-1:0] ch);
    if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        put_cell(cur_col, cur_row, CH_SPACE);
      end else if (cur_row > 0) begin
        // wrap back to the end of the previous row
        cur_row--;
        cur_col = COLS - 1;
        put_cell(cur_col, cur_row, CH_SPACE);
      end
    end else if (ch == CH_TAB) begin
      cur_col = ((cur_col + 8) / 8) * 8;
    end else if (ch == CH_RETURN) begin
      cur_col = 0;
    end else if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (ch >= CH_SPACE) begin
      put_cell(cur_col, cur_row, ch);
      cur_col++;
    end
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      scroll_screen();
      cur_row = ROWS - 1;
    end
  endfunction

  // Advance the shadow console by one request and return the result it must give
  function automatic console_view_t predict_view(console_req_t req);
    console_view_t v;
    int unsigned   c;
    int unsigned   r;
    c = clamp_to(req.column, COLS);
    r = clamp_to(req.row, ROWS);
    v.cell_data = '0;
    case (req.mode)
      MODE_PUT: apply_char(req.char_code);
      MODE_SET: begin
        cur_col = c;
        cur_row = r;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = CLEAR_CELL;
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      MODE_READ: v.cell_data = shadow_screen[r * COLS + c];
      default: ;
    endcase
    v.cursor_column = COL_IN_W'(cur_col);
    v.cursor_row    = ROW_IN_W'(cur_row);
    v.cursor_offset = OFF_W'(cur_row * COLS + cur_col);
    return v;
  endfunction

  // True when the request would make the block walk the whole screen store
  function automatic bit is_heavy(console_req_t req);
    if (req.mode == MODE_CLEAR) return 1'b1;
    if (req.mode != MODE_PUT || cur_row != ROWS - 1) return 1'b0;
    if (req.char_code == CH_NEWLINE) return 1'b1;
    if (req.char_code == CH_TAB) return ((cur_col + 8) / 8) * 8 >= COLS;
    return req.char_code >= CH_SPACE && cur_col == COLS - 1;
  endfunction

  function automatic console_req_t make_req(mode_e m, logic [CHAR_W-1:0] ch,
                                            int unsigned col, int unsigned row);
    console_req_t req;
    req.mode      = m;
    req.char_code = ch;
    req.column    = COL_IN_W'(col);
    req.row       = ROW_IN_W'(row);
    return req;
  endfunction

  function automatic console_req_t rand_req();
    console_req_t req;
    int unsigned  pick;
    req.mode      = mode_e'($urandom_range(0, 3));
    req.char_code = CHAR_W'($urandom_range(0, 255));
    req.column    = COL_IN_W'($urandom_range(0, 127));
    req.row       = ROW_IN_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      req.mode = MODE_PUT;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: req.char_code = CHAR_W'($urandom_range(32, 255));
        6, 7: begin
          case ($urandom_range(0, 3))
            0:       req.char_code = CH_BACKSPACE;
            1:       req.char_code = CH_TAB;
            2:       req.char_code = CH_NEWLINE;
            default: req.char_code = CH_RETURN;
          endcase
        end
        8:       req.char_code = CH_BACKSPACE;
        default: req.char_code = CHAR_W'($urandom_range(0, 31));
      endcase
    end else if (pick < 98) begin
      req.mode = (pick < 80) ? MODE_SET : MODE_READ;
      // mostly in range; the rest exercise the clamp
      if ($urandom_range(0, 3) != 0) begin
        req.column = COL_IN_W'($urandom_range(0, COLS - 1));
        req.row    = ROW_IN_W'($urandom_range(0, ROWS - 1));
      end
    end else begin
      req.mode = MODE_CLEAR;
    end
    if (is_heavy(req)) begin
      if (heavy_left == 0) begin
        req.mode = MODE_SET;
        req.row  = ROW_IN_W'($urandom_range(0, ROWS - 2));
      end else begin
        heavy_left--;
      end
    end
    return req;
  endfunction

  // Offer one request and hold it until the transfer happens
  task automatic send_req(console_req_t req);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    view_q.push_back(predict_view(req));
    sent_count++;
  endtask

  task automatic pause_tx(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 24'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    pause_tx(0);
    while (view_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] a);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_attr = a;
    cfg_count++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_req(make_req(MODE_PUT, 8'h41, 0, 0));
    send_req(make_req(MODE_READ, 8'h00, 0, 0));
  endtask

  task automatic test_clear_screen();
    // clearing ignores the attribute and every other field
    write_attribute(8'hA5);
    send_req(make_req(MODE_CLEAR, 8'h5A, 127, 31));
    send_req(make_req(MODE_READ, 8'h00, COLS - 1, ROWS - 1));
  endtask

  task automatic test_put_cases();
    send_req(make_req(MODE_PUT, 8'h00, 0, 0));
    send_req(make_req(MODE_PUT, 8'h1F, 0, 0));
    send_req(make_req(MODE_PUT, CH_SPACE, 0, 0));
    send_req(make_req(MODE_PUT, 8'hFF, 0, 0));
    send_req(make_req(MODE_PUT, CH_TAB, 0, 0));
    send_req(make_req(MODE_PUT, CH_RETURN, 0, 0));
    send_req(make_req(MODE_PUT, 8'h7F, 0, 0));
    send_req(make_req(MODE_PUT, CH_NEWLINE, 0, 0));
    // backspace from column 0 of row 1 wraps to the end of row 0
    send_req(make_req(MODE_PUT, CH_BACKSPACE, 0, 0));
    send_req(make_req(MODE_READ, 8'h00, COLS - 1, 0));
    send_req(make_req(MODE_SET, 8'h00, 0, 0));
    send_req(make_req(MODE_PUT, CH_BACKSPACE, 0, 0));
    send_req(make_req(MODE_SET, 8'h00, 127, 31));
    // last cell: column overflow then row overflow
    send_req(make_req(MODE_PUT, 8'h5A, 0, 0));
    send_req(make_req(MODE_READ, 8'h00, COLS - 1, ROWS - 2));
    send_req(make_req(MODE_READ, 8'h00, 127, 31));
    send_req(make_req(MODE_SET, 8'h00, COLS - 5, ROWS - 1));
    send_req(make_req(MODE_PUT, CH_TAB, 0, 0));
    send_req(make_req(MODE_PUT, CH_NEWLINE, 0, 0));
  endtask

  task automatic test_attribute_extremes();
    int unsigned c;
    int unsigned r;
    for (int k = 0; k < 2; k++) begin
      write_attribute(k == 0 ? 8'h00 : 8'hFF);
      c = cur_col;
      r = cur_row;
      send_req(make_req(MODE_PUT, 8'h61 + CHAR_W'(k), 0, 0));
      send_req(make_req(MODE_READ, 8'h00, c, r));
    end
  endtask

  task automatic test_random_traffic(int phases);
    int unsigned burst;
    int          sent_here;
    for (int p = 0; p < phases; p++) begin
      write_attribute(ATTR_W'($urandom_range(0, 255)));
      sent_here = 0;
      while (sent_here < RANDOM_ITEMS / RANDOM_PHASES) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          if (sent_here < RANDOM_ITEMS / RANDOM_PHASES) begin
            send_req(rand_req());
            sent_here++;
          end
        end
        // one phase in four runs back to back
        if (p % 4 != 3) pause_tx($urandom_range(0, 12));
      end
    end
  endtask

  task automatic test_full_output_stall();
    drain_results();
    rx_hold_req = 1'b1;
    // short requests only, so the block backs up well within the hold-off
    for (int k = 0; k < 12; k++) begin
      send_req(make_req((k % 2 == 0) ? MODE_SET : MODE_READ, 8'h00,
                        $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1)));
    end
    drain_results();
  endtask

  // Receiver: switch between stall styles, with a long hold-off on request
  initial begin : rx_pattern
    int unsigned style;
    int unsigned left;
    style = 0;
    left  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
        hold_count++;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left  = $urandom_range(32, 400);
        end
        left--;
        case (style)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= ($urandom_range(0, 9) < 7);
          2:       m_axis_tready_i <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                      logic [CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    console_view_t got;
    console_view_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[38:0];
      seen_count++;
      if (view_q.size() == 0) begin
        $error("result transfer with no request outstanding: tdata 0x%0h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = view_q.pop_front();
        check_field("cursor_column", CELL_W'(want.cursor_column), CELL_W'(got.cursor_column));
        check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
        check_field("cursor_offset", CELL_W'(want.cursor_offset), CELL_W'(got.cursor_offset));
        check_field("cell_data", want.cell_data, got.cell_data);
        check_field("tdata pad", '0, CELL_W'(m_axis_tdata_o[39]));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycles, view_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_sequence
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_clear_screen();
    test_put_cases();
    test_attribute_extremes();
    test_random_traffic(RANDOM_PHASES / 2);
    test_full_output_stall();
    test_random_traffic(RANDOM_PHASES / 2);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (view_q.size() != 0) begin
      $error("%0d expected results never arrived", view_q.size());
      err_count++;
    end

    $display("Sent %0d requests, checked %0d results: %0d scrolls, %0d clears, %0d attribute writes",
             sent_count, seen_count, scroll_count, clear_count, cfg_count);
    $display("Receiver held off %0d time(s) for %0d cycles with the input backed up; %0d errors",
             hold_count, HOLD_CYCLES, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
